// ===== rtl/core/hbwd_pkg.sv =====
// ----------------------------------------------------------------------------
// hbwd_pkg: shared types and constants for the heartbeat watchdog
// Command and mode codes, register indexes, reset values and the structs
// passed between the register file, the engine and the top level.
// ----------------------------------------------------------------------------
package hbwd_pkg;

    localparam int unsigned COUNTER_WIDTH_DEF = 16;
    localparam int unsigned CFG_IDX_W         = 3;
    localparam int unsigned CFG_DATA_W        = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STALL_TIMEOUT  = 3'd0,
        REG_SLOW_PERIOD    = 3'd1,
        REG_MID_PERIOD     = 3'd2,
        REG_FAST_PERIOD    = 3'd3,
        REG_LOW_THRESHOLD  = 3'd4,
        REG_HIGH_THRESHOLD = 3'd5,
        REG_SELFTEST_DWELL = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_KICK  = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_FORCE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_BOOT  = 3'b001,
        MODE_RUN   = 3'b010,
        MODE_FAULT = 3'b100
    } mode_t;

    localparam logic [1:0] HEALTH_BOOT  = 2'd0;
    localparam logic [1:0] HEALTH_RUN   = 2'd1;
    localparam logic [1:0] HEALTH_FAULT = 2'd2;

    // rgb order: red is the MSB
    localparam logic [2:0] LED_OFF   = 3'b000;
    localparam logic [2:0] LED_RED   = 3'b100;
    localparam logic [2:0] LED_GREEN = 3'b010;
    localparam logic [2:0] LED_BLUE  = 3'b001;

    localparam logic [15:0] STALL_TIMEOUT_RST  = 16'd20;
    localparam logic [15:0] SLOW_PERIOD_RST    = 16'd20;
    localparam logic [15:0] MID_PERIOD_RST     = 16'd8;
    localparam logic [15:0] FAST_PERIOD_RST    = 16'd3;
    localparam logic [9:0]  LOW_THRESHOLD_RST  = 10'd200;
    localparam logic [9:0]  HIGH_THRESHOLD_RST = 10'd700;
    localparam logic [7:0]  SELFTEST_DWELL_RST = 8'd2;

    typedef struct packed {
        logic [15:0] stall_timeout;
        logic [15:0] slow_period;
        logic [15:0] mid_period;
        logic [15:0] fast_period;
        logic [9:0]  low_threshold;
        logic [9:0]  high_threshold;
        logic [7:0]  selftest_dwell;
    } cfg_t;

    typedef struct packed {
        cmd_t       command;
        logic [9:0] load_level;
        logic       fault_on;
    } cmd_req_t;

    typedef struct packed {
        logic [2:0] led;
        logic [1:0] health;
        logic       selftest_active;
    } status_t;

    function automatic logic [1:0] health_code(mode_t m);
        logic [1:0] code;
        unique case (m)
            MODE_RUN:   code = HEALTH_RUN;
            MODE_FAULT: code = HEALTH_FAULT;
            default:    code = HEALTH_BOOT;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/core/hbwd_regs.sv =====
// ----------------------------------------------------------------------------
// hbwd_regs: configuration register file
// Seven writable registers, always ready; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module hbwd_regs
    import hbwd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_STALL_TIMEOUT:  cfg_next.stall_timeout  = cfg_data[15:0];
                REG_SLOW_PERIOD:    cfg_next.slow_period    = cfg_data[15:0];
                REG_MID_PERIOD:     cfg_next.mid_period     = cfg_data[15:0];
                REG_FAST_PERIOD:    cfg_next.fast_period    = cfg_data[15:0];
                REG_LOW_THRESHOLD:  cfg_next.low_threshold  = cfg_data[9:0];
                REG_HIGH_THRESHOLD: cfg_next.high_threshold = cfg_data[9:0];
                REG_SELFTEST_DWELL: cfg_next.selftest_dwell = cfg_data[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stall_timeout  <= STALL_TIMEOUT_RST;
            cfg_reg.slow_period    <= SLOW_PERIOD_RST;
            cfg_reg.mid_period     <= MID_PERIOD_RST;
            cfg_reg.fast_period    <= FAST_PERIOD_RST;
            cfg_reg.low_threshold  <= LOW_THRESHOLD_RST;
            cfg_reg.high_threshold <= HIGH_THRESHOLD_RST;
            cfg_reg.selftest_dwell <= SELFTEST_DWELL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/hbwd_engine.sv =====
// ----------------------------------------------------------------------------
// hbwd_engine: watchdog state and single-pass command update
// Holds mode, stall and blink counters and the self-test sequencer; on each
// step applies one command and presents the resulting status.
// ----------------------------------------------------------------------------
module hbwd_engine
    import hbwd_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  cmd_req_t req,
    input  cfg_t     cfg,
    output status_t  status
);

    localparam int unsigned CMP_W = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;
    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

    mode_t                    mode_reg, mode_next;
    logic                     kick_reg, kick_next;
    logic [COUNTER_WIDTH-1:0] stall_reg, stall_next;
    logic                     forced_reg, forced_next;
    logic                     green_reg, green_next;
    logic [15:0]              interval_reg, interval_next;
    logic [COUNTER_WIDTH-1:0] blink_reg, blink_next;
    logic [1:0]               test_step_reg, test_step_next;
    logic                     test_done_reg, test_done_next;
    logic [7:0]               dwell_reg, dwell_next;
    logic [2:0]               led_reg, led_next;
    logic [7:0]               dwell_inc;

    function automatic logic [2:0] show_led(mode_t m, logic phase);
        logic [2:0] led;
        if (m == MODE_RUN)
        begin
            led = phase ? LED_GREEN : LED_OFF;
        end
        else
        begin
            led = LED_RED;
        end
        return led;
    endfunction

    assign dwell_inc = dwell_reg + 8'd1;

    always_comb
    begin
        mode_next      = mode_reg;
        kick_next      = kick_reg;
        stall_next     = stall_reg;
        forced_next    = forced_reg;
        green_next     = green_reg;
        interval_next  = interval_reg;
        blink_next     = blink_reg;
        test_step_next = test_step_reg;
        test_done_next = test_done_reg;
        dwell_next     = dwell_reg;
        led_next       = led_reg;

        if (step)
        begin
            unique case (req.command)
                CMD_TICK:
                begin
                    if (!test_done_reg)
                    begin
                        if (test_step_reg == 2'd3)
                        begin
                            test_done_next = 1'b1;
                            led_next       = show_led(mode_reg, green_reg);
                        end
                        else
                        begin
                            unique case (test_step_reg)
                                2'd0:    led_next = LED_BLUE;
                                2'd1:    led_next = LED_RED;
                                default: led_next = LED_GREEN;
                            endcase
                            if (dwell_inc >= cfg.selftest_dwell)
                            begin
                                dwell_next     = '0;
                                test_step_next = test_step_reg + 2'd1;
                                // last colour done: leave the self-test
                                if (test_step_reg == 2'd2)
                                begin
                                    test_done_next = 1'b1;
                                    led_next       = show_led(mode_reg, green_reg);
                                end
                            end
                            else
                            begin
                                dwell_next = dwell_inc;
                            end
                        end
                    end
                    else
                    begin
                        priority if (forced_reg)
                        begin
                            mode_next = MODE_FAULT;
                        end
                        else if (!kick_reg)
                        begin
                            if (stall_reg != CNT_MAX)
                            begin
                                stall_next = stall_reg + 1'b1;
                            end
                            if (CMP_W'(stall_next) >= CMP_W'(cfg.stall_timeout))
                            begin
                                mode_next  = MODE_FAULT;
                                green_next = 1'b0;
                            end
                        end
                        else
                        begin
                            stall_next = '0;
                            kick_next  = 1'b0;
                            mode_next  = MODE_RUN;
                        end

                        if (mode_next == MODE_RUN)
                        begin
                            blink_next = blink_reg + 1'b1;
                            if (CMP_W'(blink_next) >= CMP_W'(interval_reg))
                            begin
                                blink_next = '0;
                                green_next = ~green_next;
                            end
                        end
                        else
                        begin
                            green_next = 1'b0;
                        end
                        led_next = show_led(mode_next, green_next);
                    end
                end
                CMD_KICK:
                begin
                    kick_next = 1'b1;
                end
                CMD_LOAD:
                begin
                    priority if (req.load_level <= cfg.low_threshold)
                    begin
                        interval_next = cfg.slow_period;
                    end
                    else if (req.load_level <= cfg.high_threshold)
                    begin
                        interval_next = cfg.mid_period;
                    end
                    else
                    begin
                        interval_next = cfg.fast_period;
                    end
                end
                CMD_FORCE:
                begin
                    test_done_next = 1'b1;
                    if (req.fault_on)
                    begin
                        forced_next = 1'b1;
                        mode_next   = MODE_FAULT;
                        green_next  = 1'b0;
                    end
                    else
                    begin
                        forced_next = 1'b0;
                        stall_next  = '0;
                        kick_next   = 1'b0;
                        mode_next   = MODE_RUN;
                    end
                    led_next = show_led(mode_next, green_next);
                end
                default:
                begin
                    kick_next = kick_reg;
                end
            endcase
        end
    end

    assign status.led             = led_next;
    assign status.health          = health_code(mode_next);
    assign status.selftest_active = ~test_done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_BOOT;
            kick_reg      <= 1'b0;
            stall_reg     <= '0;
            forced_reg    <= 1'b0;
            green_reg     <= 1'b0;
            interval_reg  <= SLOW_PERIOD_RST;
            blink_reg     <= '0;
            test_step_reg <= 2'd0;
            test_done_reg <= 1'b0;
            dwell_reg     <= 8'd0;
            led_reg       <= LED_RED;
        end
        else
        begin
            mode_reg      <= mode_next;
            kick_reg      <= kick_next;
            stall_reg     <= stall_next;
            forced_reg    <= forced_next;
            green_reg     <= green_next;
            interval_reg  <= interval_next;
            blink_reg     <= blink_next;
            test_step_reg <= test_step_next;
            test_done_reg <= test_done_next;
            dwell_reg     <= dwell_next;
            led_reg       <= led_next;
        end
    end

`ifndef SYNTHESIS
    a_boot_during_selftest: assert property (@(posedge clk) disable iff (!rst_n)
        !test_done_reg |-> (mode_reg == MODE_BOOT))
        else $error("mode left boot before the self-test finished");

    a_forced_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
        forced_reg |-> (mode_reg == MODE_FAULT))
        else $error("forced fault without fault mode");

    a_run_led_green_only: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_RUN) |-> (!led_reg[2] && !led_reg[0]))
        else $error("red or blue lit in run mode");
`endif

endmodule

// ===== rtl/core/heartbeat_watchdog_led.sv =====
// ----------------------------------------------------------------------------
// heartbeat_watchdog_led: heartbeat watchdog with an RGB status LED
// Path: a transfer loads the input reg; when the result slot is free or
// draining the command is processed and the status loads the result reg.
// Throughput: one command per cycle unless out_stall blocks; single-pass update.
// Reset: async active low; engine LED red, mode boot, config registers to their defaults.
// ----------------------------------------------------------------------------
module heartbeat_watchdog_led
    import hbwd_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            command,
    input  logic [9:0]            load_level,
    input  logic                  fault_on,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  led_red,
    output logic                  led_green,
    output logic                  led_blue,
    output logic [1:0]            health_mode,
    output logic                  selftest_active,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t     cfg;
    cmd_req_t req_reg;
    logic     req_valid_reg, req_valid_next;
    status_t  status;
    status_t  result_reg;
    logic     out_valid_reg, out_valid_next;
    logic     advance;
    logic     step;
    logic     in_xfer;

    hbwd_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hbwd_engine #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .req    (req_reg),
        .cfg    (cfg),
        .status (status)
    );

    // result slot is free or being drained this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = req_valid_reg && advance;
    assign in_stall = req_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        priority if (in_xfer)
        begin
            req_valid_next = 1'b1;
        end
        else if (step)
        begin
            req_valid_next = 1'b0;
        end
        else
        begin
            req_valid_next = req_valid_reg;
        end

        priority if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: load on input transfer or step only
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg.command    <= cmd_t'(command);
            req_reg.load_level <= load_level;
            req_reg.fault_on   <= fault_on;
        end
        if (step)
        begin
            result_reg <= status;
        end
    end

    assign out_valid       = out_valid_reg;
    assign led_red         = result_reg.led[2];
    assign led_green       = result_reg.led[1];
    assign led_blue        = result_reg.led[0];
    assign health_mode     = result_reg.health;
    assign selftest_active = result_reg.selftest_active;

`ifndef SYNTHESIS
    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed command produced no result");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> req_valid_reg)
        else $error("input stalled with an empty input stage");

    a_blocked_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && out_valid_reg && out_stall) |=> req_valid_reg)
        else $error("blocked command dropped from the input stage");
`endif

endmodule
